### rtl/hcf_pkg.sv
// Shared widths, register indexes and saturation helpers of the Hermite curve flattener.
`default_nettype none
package hcf_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_LEVELS_DEF = 5;

    localparam int W_WORD = 32;
    localparam int W_WIDE = 56;
    localparam int W_VTX  = 2 * W_WORD;
    localparam int W_MA   = 34;
    localparam int W_MB   = W_WIDE;
    localparam int W_HALF = W_MB / 2;
    localparam int W_PP   = W_MA + W_HALF;
    localparam int W_MAG  = W_MA + W_MB;
    localparam int W_PROD = W_MAG + 1;
    localparam int W_EXT  = W_PROD + 1;
    localparam int OVF_BIT = 63;

    localparam int W_CFG_IDX = 3;
    localparam logic [W_CFG_IDX-1:0] CFG_SCALE_X  = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_OFFSET_X = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_SCALE_Y  = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_OFFSET_Y = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_LIMIT    = 3'd4;

    localparam logic signed [W_WIDE-1:0] WIDE_MAX = {1'b0, {(W_WIDE-1){1'b1}}};
    localparam logic signed [W_WIDE-1:0] WIDE_MIN = {1'b1, {(W_WIDE-1){1'b0}}};
    localparam logic signed [W_WORD-1:0] WORD_MAX = {1'b0, {(W_WORD-1){1'b1}}};
    localparam logic signed [W_WORD-1:0] WORD_MIN = {1'b1, {(W_WORD-1){1'b0}}};

    function automatic logic signed [W_WIDE-1:0] sat_wide(input logic signed [W_EXT-1:0] v);
        logic signed [W_WIDE-1:0] res;
        if (v > W_EXT'(WIDE_MAX)) begin
            res = WIDE_MAX;
        end else if (v < W_EXT'(WIDE_MIN)) begin
            res = WIDE_MIN;
        end else begin
            res = W_WIDE'(v);
        end
        return res;
    endfunction

    function automatic logic signed [W_WORD-1:0] sat_word(input logic signed [W_EXT-1:0] v);
        logic signed [W_WORD-1:0] res;
        if (v > W_EXT'(WORD_MAX)) begin
            res = WORD_MAX;
        end else if (v < W_EXT'(WORD_MIN)) begin
            res = WORD_MIN;
        end else begin
            res = W_WORD'(v);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/adaptive_hermite_curve_flattener.sv
// Operation: a first point is only stored; a segment computes its coefficients, converts both
// endpoints, then refines interior vertices (ten multiplies each on the shared unit plus the
// neighbor reads) and finally emits every stored vertex, held by any output stall.
// Throughput: one point at a time; the input is not ready until the last vertex is taken.
// Reset: synchronous active low; clears the sequencer and the stored point and loads the config defaults.
`default_nettype none
module adaptive_hermite_curve_flattener
    import hcf_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // pos_x, pos_y, vel_x, vel_y, time_stamp
    input  wire logic [159:0]         i_s_tdata,
    // first_point
    input  wire logic [0:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // pixel_x, pixel_y
    output logic [63:0]               o_m_tdata,
    // pen_down, capped
    output logic [1:0]                o_m_tuser,
    output logic                      o_m_tlast,
    input  wire logic                 i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0] i_cfg_idx,
    input  wire logic [W_WORD-1:0]    i_cfg_data
);

    localparam int DEPTH = (1 << MAX_LEVELS) + 1;
    localparam int AW    = MAX_LEVELS + 1;
    localparam int W_LVL = $clog2(MAX_LEVELS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ISSUE = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_RDA   = 9'b000001000,
        ST_RDB   = 9'b000010000,
        ST_MID   = 9'b000100000,
        ST_ORD   = 9'b001000000,
        ST_OLOAD = 9'b010000000,
        ST_OWAIT = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        OP_C0, OP_C1, OP_C2, OP_PIX, OP_HOR, OP_SQX, OP_SQY
    } t_op;

    typedef enum logic [1:0] {
        VM_END0, VM_END1, VM_MID
    } t_vmode;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_vmode r_mode, n_mode;
    logic   r_ax, n_ax;
    logic [1:0] r_hi, n_hi;
    logic [W_LVL-1:0] r_lvl, n_lvl;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_oi, n_oi;
    logic r_ok, n_ok;
    logic r_capped, n_capped;
    logic r_out_valid, n_out_valid;
    logic signed [W_WORD-1:0] r_prev [5];
    logic signed [W_WORD-1:0] n_prev [5];
    logic signed [W_WORD-1:0] r_cur [5];
    logic signed [W_WORD-1:0] n_cur [5];
    logic signed [W_WORD-1:0] r_scale [2];
    logic signed [W_WORD-1:0] r_offset [2];
    logic [W_WORD-1:0] r_limit;

    logic signed [W_WIDE-1:0] r_coef [2][4];
    logic signed [W_WIDE-1:0] n_coef [2][4];
    logic signed [W_WIDE-1:0] r_h, n_h;
    logic signed [W_WORD-1:0] r_px, n_px, r_py, n_py;
    logic signed [W_WORD-1:0] r_nbx, n_nbx, r_nby, n_nby;
    logic [W_WORD-1:0] r_mx, n_mx, r_my, n_my;
    logic [63:0] r_esum, n_esum;
    logic [W_VTX-1:0] r_out_xy, n_out_xy;
    logic r_out_pen, n_out_pen, r_out_last, n_out_last;

    logic mul_start, mul_done, mul_ovf;
    logic signed [W_MA-1:0] mul_a;
    logic signed [W_MB-1:0] mul_b;
    logic signed [W_PROD-1:0] mul_prod;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [W_VTX-1:0] mem_wdata, mem_rdata;

    logic signed [W_MB-1:0] dt;
    logic signed [W_WORD-1:0] p0, p1, v0, v1;
    logic signed [W_WIDE-1:0] fq;
    logic signed [W_WORD-1:0] pix;
    logic signed [W_WIDE-1:0] hv;
    logic signed [W_EXT-1:0] dpos;
    logic [W_LVL-1:0] sh;
    logic [AW-1:0] k_addr, span;
    logic [AW:0] k_next;
    logic [63:0] e_sum;
    logic e_fail, ok_now;

    hcf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod),
        .o_ovf   (mul_ovf)
    );

    hcf_vstore #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign p0 = r_prev[r_ax ? 1 : 0];
    assign p1 = r_cur[r_ax ? 1 : 0];
    assign v0 = r_prev[r_ax ? 3 : 2];
    assign v1 = r_cur[r_ax ? 3 : 2];
    assign dt = W_MB'(r_cur[4]) - W_MB'(r_prev[4]);
    assign dpos = W_EXT'(p1) - W_EXT'(p0);
    assign sh = W_LVL'(MAX_LEVELS) - r_lvl;
    assign k_addr = AW'(r_k << sh);
    assign span = AW'(1) << r_lvl;
    assign k_next = (AW + 1)'(r_k) + (AW + 1)'(2);

    assign fq = mul_ovf ? (mul_prod[W_PROD-1] ? WIDE_MIN : WIDE_MAX)
                        : sat_wide(W_EXT'(mul_prod >>> FRAC_BITS));
    assign pix = sat_word(W_EXT'(mul_prod >>> FRAC_BITS) + W_EXT'(r_offset[r_ax]));
    assign hv = sat_wide(W_EXT'(mul_prod >>> r_lvl) + W_EXT'(r_coef[r_ax][r_hi]));
    assign e_sum = 64'((W_EXT'(r_esum) + W_EXT'(mul_prod)) >> FRAC_BITS);
    assign e_fail = e_sum >= 64'(r_limit);
    assign ok_now = r_ok & ~e_fail;
    assign mul_start = (r_state == ST_ISSUE);

    always_comb begin
        case (r_op)
            OP_C0: begin
                mul_a = W_MA'(v1) + W_MA'(v0);
                mul_b = dt;
            end
            OP_C1: begin
                mul_a = (W_MA'(v0) <<< 1) + W_MA'(v1);
                mul_b = dt;
            end
            OP_C2: begin
                mul_a = W_MA'(v0);
                mul_b = dt;
            end
            OP_PIX: begin
                mul_a = W_MA'(r_scale[r_ax]);
                mul_b = r_h;
            end
            OP_HOR: begin
                mul_a = signed'(W_MA'(r_k));
                mul_b = r_h;
            end
            OP_SQX: begin
                mul_a = signed'(W_MA'(r_mx));
                mul_b = signed'(W_MB'(r_mx));
            end
            default: begin
                mul_a = signed'(W_MA'(r_my));
                mul_b = signed'(W_MB'(r_my));
            end
        endcase
    end

    always_comb begin
        logic signed [W_WORD:0] mid_x, mid_y;
        logic signed [W_WORD+1:0] dx, dy;
        logic [W_WORD+1:0] ax_mag, ay_mag;
        n_state = r_state;
        n_op = r_op;
        n_mode = r_mode;
        n_ax = r_ax;
        n_hi = r_hi;
        n_lvl = r_lvl;
        n_k = r_k;
        n_oi = r_oi;
        n_ok = r_ok;
        n_capped = r_capped;
        n_out_valid = r_out_valid;
        n_prev = r_prev;
        n_cur = r_cur;
        n_coef = r_coef;
        n_h = r_h;
        n_px = r_px;
        n_py = r_py;
        n_nbx = r_nbx;
        n_nby = r_nby;
        n_mx = r_mx;
        n_my = r_my;
        n_esum = r_esum;
        n_out_xy = r_out_xy;
        n_out_pen = r_out_pen;
        n_out_last = r_out_last;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        mid_x = (W_WORD + 1)'(signed'(r_nbx)) + (W_WORD + 1)'(signed'(mem_rdata[31:0]));
        mid_y = (W_WORD + 1)'(signed'(r_nby)) + (W_WORD + 1)'(signed'(mem_rdata[63:32]));
        dx = (W_WORD + 2)'(mid_x >>> 1) - (W_WORD + 2)'(r_px);
        dy = (W_WORD + 2)'(mid_y >>> 1) - (W_WORD + 2)'(r_py);
        ax_mag = dx[W_WORD+1] ? unsigned'(-dx) : unsigned'(dx);
        ay_mag = dy[W_WORD+1] ? unsigned'(-dy) : unsigned'(dy);

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    for (int i = 0; i < 5; i++) begin
                        n_cur[i] = signed'(i_s_tdata[i*W_WORD +: W_WORD]);
                    end
                    if (i_s_tuser[0]) begin
                        n_prev = n_cur;
                    end else begin
                        n_ax = 1'b0;
                        n_capped = 1'b0;
                        n_op = OP_C0;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_ISSUE;
                    case (r_op)
                        OP_C0: begin
                            n_coef[r_ax][0] = sat_wide(W_EXT'(fq) - (dpos <<< 1));
                            n_op = OP_C1;
                        end
                        OP_C1: begin
                            n_coef[r_ax][1] = sat_wide((dpos <<< 1) + dpos - W_EXT'(fq));
                            n_op = OP_C2;
                        end
                        OP_C2: begin
                            n_coef[r_ax][2] = fq;
                            n_coef[r_ax][3] = W_WIDE'(p0);
                            if (!r_ax) begin
                                n_ax = 1'b1;
                                n_op = OP_C0;
                            end else begin
                                n_ax = 1'b0;
                                n_mode = VM_END0;
                                n_h = W_WIDE'(r_prev[0]);
                                n_op = OP_PIX;
                            end
                        end
                        OP_PIX: begin
                            if (!r_ax) begin
                                n_px = pix;
                                n_ax = 1'b1;
                                case (r_mode)
                                    VM_END0: n_h = W_WIDE'(r_prev[1]);
                                    VM_END1: n_h = W_WIDE'(r_cur[1]);
                                    default: begin
                                        n_h = r_coef[1][0];
                                        n_hi = 2'd1;
                                        n_op = OP_HOR;
                                    end
                                endcase
                            end else begin
                                n_py = pix;
                                n_ax = 1'b0;
                                mem_we = 1'b1;
                                mem_wdata = {pix, r_px};
                                case (r_mode)
                                    VM_END0: begin
                                        mem_waddr = '0;
                                        n_mode = VM_END1;
                                        n_h = W_WIDE'(r_cur[0]);
                                    end
                                    VM_END1: begin
                                        mem_waddr = LAST_ADDR;
                                        n_mode = VM_MID;
                                        n_lvl = W_LVL'(1);
                                        n_k = AW'(1);
                                        n_ok = 1'b1;
                                        n_h = r_coef[0][0];
                                        n_hi = 2'd1;
                                        n_op = OP_HOR;
                                    end
                                    default: begin
                                        mem_waddr = k_addr;
                                        n_state = ST_RDA;
                                    end
                                endcase
                            end
                        end
                        OP_HOR: begin
                            n_h = hv;
                            if (r_hi == 2'd3) begin
                                n_op = OP_PIX;
                            end else begin
                                n_hi = r_hi + 2'd1;
                            end
                        end
                        OP_SQX: begin
                            n_esum = 64'(mul_prod);
                            n_op = OP_SQY;
                        end
                        default: begin
                            n_ok = ok_now;
                            n_ax = 1'b0;
                            n_hi = 2'd1;
                            n_h = r_coef[0][0];
                            n_op = OP_HOR;
                            if (k_next < (AW + 1)'(span)) begin
                                n_k = AW'(k_next);
                            end else if (ok_now) begin
                                n_oi = '0;
                                n_state = ST_ORD;
                            end else if (r_lvl == W_LVL'(MAX_LEVELS)) begin
                                n_capped = 1'b1;
                                n_oi = '0;
                                n_state = ST_ORD;
                            end else begin
                                n_lvl = r_lvl + W_LVL'(1);
                                n_k = AW'(1);
                                n_ok = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_RDA: begin
                mem_raddr = AW'((r_k - AW'(1)) << sh);
                n_state = ST_RDB;
            end
            ST_RDB: begin
                mem_raddr = AW'((r_k + AW'(1)) << sh);
                n_nbx = signed'(mem_rdata[31:0]);
                n_nby = signed'(mem_rdata[63:32]);
                n_state = ST_MID;
            end
            ST_MID: begin
                n_mx = ax_mag[W_WORD+1:W_WORD-1] != '0 ? {1'b1, {(W_WORD-1){1'b0}}}
                                                         : ax_mag[W_WORD-1:0];
                n_my = ay_mag[W_WORD+1:W_WORD-1] != '0 ? {1'b1, {(W_WORD-1){1'b0}}}
                                                         : ay_mag[W_WORD-1:0];
                n_op = OP_SQX;
                n_state = ST_ISSUE;
            end
            ST_ORD: begin
                mem_raddr = AW'(r_oi << sh);
                n_state = ST_OLOAD;
            end
            ST_OLOAD: begin
                n_out_xy = mem_rdata;
                n_out_pen = (r_oi != '0);
                n_out_last = (r_oi == span);
                n_out_valid = 1'b1;
                n_state = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (i_m_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_prev = r_cur;
                        n_state = ST_IDLE;
                    end else begin
                        n_oi = r_oi + AW'(1);
                        n_state = ST_ORD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op <= OP_C0;
            r_mode <= VM_END0;
            r_ax <= 1'b0;
            r_hi <= 2'd1;
            r_lvl <= W_LVL'(1);
            r_k <= '0;
            r_oi <= '0;
            r_ok <= 1'b0;
            r_capped <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_prev[i] <= '0;
            end
            r_scale[0] <= 32'sd65536;
            r_scale[1] <= 32'sd65536;
            r_offset[0] <= '0;
            r_offset[1] <= '0;
            r_limit <= 32'd409600;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_mode <= n_mode;
            r_ax <= n_ax;
            r_hi <= n_hi;
            r_lvl <= n_lvl;
            r_k <= n_k;
            r_oi <= n_oi;
            r_ok <= n_ok;
            r_capped <= n_capped;
            r_out_valid <= n_out_valid;
            r_prev <= n_prev;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCALE_X:  r_scale[0] <= signed'(i_cfg_data);
                    CFG_OFFSET_X: r_offset[0] <= signed'(i_cfg_data);
                    CFG_SCALE_Y:  r_scale[1] <= signed'(i_cfg_data);
                    CFG_OFFSET_Y: r_offset[1] <= signed'(i_cfg_data);
                    CFG_LIMIT:    r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_coef <= n_coef;
        r_h <= n_h;
        r_px <= n_px;
        r_py <= n_py;
        r_nbx <= n_nbx;
        r_nby <= n_nby;
        r_mx <= n_mx;
        r_my <= n_my;
        r_esum <= n_esum;
        r_out_xy <= n_out_xy;
        r_out_pen <= n_out_pen;
        r_out_last <= n_out_last;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out_xy;
    assign o_m_tuser = {r_capped, r_out_pen};
    assign o_m_tlast = r_out_last;

endmodule
`default_nettype wire

### rtl/hcf_mul.sv
// Shared sign-magnitude multiplier built from two partial products, computed in sequence.
`default_nettype none
module hcf_mul
    import hcf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [W_MA-1:0]   i_a,
    input  wire logic signed [W_MB-1:0]   i_b,
    output logic                          o_done,
    output logic signed [W_PROD-1:0]      o_prod,
    output logic                          o_ovf
);

    logic              r_run;
    logic [1:0]        r_cnt;
    logic              r_done;
    logic [W_MA-1:0]   r_ua;
    logic [W_MB-1:0]   r_ub;
    logic              r_neg;
    logic [W_PP-1:0]   r_pp;
    logic [W_MAG-1:0]  r_acc;
    logic signed [W_PROD-1:0] r_prod;
    logic              r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[W_MA-1] ? unsigned'(-i_a) : unsigned'(i_a);
            r_ub  <= i_b[W_MB-1] ? unsigned'(-i_b) : unsigned'(i_b);
            r_neg <= i_a[W_MA-1] ^ i_b[W_MB-1];
        end else if (r_run) begin
            case (r_cnt)
                2'd0: begin
                    r_pp <= W_PP'(r_ua) * W_PP'(r_ub[W_HALF-1:0]);
                end
                2'd1: begin
                    r_acc <= W_MAG'(r_pp);
                    r_pp  <= W_PP'(r_ua) * W_PP'(r_ub[W_MB-1:W_HALF]);
                end
                2'd2: begin
                    r_acc <= r_acc + (W_MAG'(r_pp) << W_HALF);
                end
                default: begin
                    r_prod <= r_neg ? -signed'(W_PROD'(r_acc)) : signed'(W_PROD'(r_acc));
                    r_ovf  <= |r_acc[W_MAG-1:OVF_BIT];
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
    assign o_ovf  = r_ovf;

endmodule
`default_nettype wire

### rtl/hcf_vstore.sv
// Vertex memory holding pixel pairs at their finest-level positions, registered read.
`default_nettype none
module hcf_vstore
    import hcf_pkg::*;
#(
    parameter int DEPTH = (1 << MAX_LEVELS_DEF) + 1,
    parameter int AW    = MAX_LEVELS_DEF + 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [W_VTX-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [W_VTX-1:0]      o_rdata
);

    logic [W_VTX-1:0] r_mem [DEPTH];
    logic [W_VTX-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
